// ===== rtl/core/acpr_pkg.sv =====
// Shared types, widths and command codes of the platform collision resolver.
// Depends on nothing; the other files of the block refer to it by scoped names or import it.
`timescale 1ns / 1ps

package acpr_pkg;

	localparam int COORD_W = 20;
	localparam int SIZE_W = 16;
	localparam int MARGIN_W = 16;
	localparam int CMD_W = 2;
	localparam int EXT_W = COORD_W + 1;

	localparam int MAX_PLATFORMS_DEF = 64;

	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam logic [MARGIN_W-1:0] PIT_MARGIN_RST = 16'd3200;
	localparam logic signed [EXT_W-1:0] LOWEST_RST = {1'b1, {(EXT_W-1){1'b0}}};

	// One stored platform.
	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] top;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
		logic deadly;
	} plat_t;

	// The moving box with its far edges already summed.
	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] top;
		logic signed [EXT_W-1:0] right;
		logic signed [EXT_W-1:0] bottom;
	} box_t;

	// Verdict of the overlap unit for one platform.
	typedef struct packed {
		logic valid;
		logic hit;
		logic vert;
		logic neg;
		logic deadly;
		logic [SIZE_W-1:0] mag;
	} hit_t;

endpackage

// ===== rtl/core/acpr_if.sv =====
// Handshake channels of the platform collision resolver: query and response.
// Depends on acpr_pkg for field widths.
`timescale 1ns / 1ps

interface acpr_req_if;
	logic valid;
	logic ready;
	logic [acpr_pkg::CMD_W-1:0] cmd;
	logic signed [acpr_pkg::COORD_W-1:0] box_left;
	logic signed [acpr_pkg::COORD_W-1:0] box_top;
	logic [acpr_pkg::SIZE_W-1:0] box_width;
	logic [acpr_pkg::SIZE_W-1:0] box_height;
	logic deadly;
	logic signed [acpr_pkg::COORD_W-1:0] vel_x;
	logic signed [acpr_pkg::COORD_W-1:0] vel_y;

	modport source (
		output valid, cmd, box_left, box_top, box_width, box_height, deadly, vel_x, vel_y,
		input ready
	);
	modport sink (
		input valid, cmd, box_left, box_top, box_width, box_height, deadly, vel_x, vel_y,
		output ready
	);
endinterface

interface acpr_rsp_if;
	logic valid;
	logic ready;
	logic signed [acpr_pkg::COORD_W-1:0] corr_x;
	logic signed [acpr_pkg::COORD_W-1:0] corr_y;
	logic signed [acpr_pkg::COORD_W-1:0] new_vel_x;
	logic signed [acpr_pkg::COORD_W-1:0] new_vel_y;
	logic on_ground;
	logic fell_in_pit;
	logic hit_deadly;

	modport source (
		output valid, corr_x, corr_y, new_vel_x, new_vel_y, on_ground, fell_in_pit,
		hit_deadly,
		input ready
	);
	modport sink (
		input valid, corr_x, corr_y, new_vel_x, new_vel_y, on_ground, fell_in_pit,
		hit_deadly,
		output ready
	);
endinterface

// ===== rtl/core/aabb_platform_collision_resolver.sv =====
// Platform collision resolver. A load or clear gives no item.
// A query walks the N stored platforms with one table read each, drains the read and
// the three-stage overlap unit, then hands the result to the output register; the
// next item is taken only once that hand-over is done. A pit or empty-table query
// skips the walk and the drain. A full output register stalls the hand-over.
// Asynchronous active-low reset empties the table and sets pit_margin to 3200.
`timescale 1ns / 1ps

module aabb_platform_collision_resolver #(
	parameter int MAX_PLATFORMS = acpr_pkg::MAX_PLATFORMS_DEF
) (
	input logic clk,
	input logic arst_n,
	acpr_req_if.sink req,
	acpr_rsp_if.source rsp,
	input logic cfg_we,
	input logic [acpr_pkg::MARGIN_W-1:0] cfg_wdata
);

	// Address width of the table and width of the fill count, which must hold
	// MAX_PLATFORMS itself.
	localparam int AW = (MAX_PLATFORMS > 1) ? $clog2(MAX_PLATFORMS) : 1;
	localparam int CW = $clog2(MAX_PLATFORMS + 1);
	// The correction sums can grow to MAX_PLATFORMS times the largest overlap.
	localparam int ACC_RAW = acpr_pkg::SIZE_W + 2 + $clog2(MAX_PLATFORMS + 1);
	localparam int ACC_W = (ACC_RAW > acpr_pkg::EXT_W) ? ACC_RAW : acpr_pkg::EXT_W;
	localparam int CWD = acpr_pkg::COORD_W;
	localparam int EW = acpr_pkg::EXT_W;
	localparam int PW = EW + 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WALK = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t state_q;

	// Table bookkeeping and the pit margin register.
	logic [CW-1:0] count_q;
	logic signed [EW-1:0] lowest_q;
	logic [acpr_pkg::MARGIN_W-1:0] margin_q;

	// The query being worked on.
	acpr_pkg::box_t box_q;
	logic signed [CWD-1:0] vx_q, vy_q;
	logic signed [ACC_W-1:0] cx_q, cy_q;
	logic ground_q, hitd_q, fell_q;

	// Walk through the table.
	logic [CW-1:0] rd_idx_q;
	logic rd_vld_q;
	acpr_pkg::plat_t rd_plat;
	acpr_pkg::hit_t hit;
	logic unit_busy;

	// Output register.
	logic rsp_vld_q;
	logic signed [CWD-1:0] rsp_cx_q, rsp_cy_q, rsp_vx_q, rsp_vy_q;
	logic rsp_ground_q, rsp_fell_q, rsp_hitd_q;

	logic req_fire;
	logic table_full;
	logic is_load, is_clear, is_query;
	logic walk_last;
	logic rsp_free;
	logic signed [EW-1:0] new_bottom;
	logic signed [EW-1:0] new_right;
	logic signed [PW-1:0] pit_line;
	logic pit_fall;
	logic signed [ACC_W-1:0] mag_ext;
	logic signed [CWD-1:0] cx_sat, cy_sat;
	acpr_pkg::plat_t wr_plat;

	// The block takes an item only when no query is in flight. A finished
	// response may still sit in the output register meanwhile.
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire = req.valid && req.ready;

	assign is_load = (req.cmd == acpr_pkg::CMD_LOAD);
	assign is_clear = (req.cmd == acpr_pkg::CMD_CLEAR);
	assign is_query = (req.cmd == acpr_pkg::CMD_QUERY);
	assign table_full = (count_q == CW'(MAX_PLATFORMS));

	// Far edges of the incoming box; for a load this is the platform bottom.
	assign new_bottom = $signed({req.box_top[CWD-1], req.box_top})
		+ $signed({{(EW-acpr_pkg::SIZE_W){1'b0}}, req.box_height});
	assign new_right = $signed({req.box_left[CWD-1], req.box_left})
		+ $signed({{(EW-acpr_pkg::SIZE_W){1'b0}}, req.box_width});

	// The box has fallen when its top lies below the lowest platform bottom
	// plus the margin, or when the table is empty.
	assign pit_line = $signed({lowest_q[EW-1], lowest_q})
		+ $signed({{(PW-acpr_pkg::MARGIN_W){1'b0}}, margin_q});
	assign pit_fall = ($signed({{2{req.box_top[CWD-1]}}, req.box_top}) > pit_line)
		|| (count_q == '0);

	assign walk_last = (rd_idx_q == (count_q - CW'(1)));
	assign rsp_free = !rsp_vld_q || rsp.ready;

	assign wr_plat.left = req.box_left;
	assign wr_plat.top = req.box_top;
	assign wr_plat.width = req.box_width;
	assign wr_plat.height = req.box_height;
	assign wr_plat.deadly = req.deadly;

	acpr_plat_ram #(
		.DEPTH (MAX_PLATFORMS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (req_fire && is_load && !table_full),
		.waddr (count_q[AW-1:0]),
		.wdata (wr_plat),
		.re    (state_q == ST_WALK),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (rd_plat)
	);

	acpr_overlap_unit u_ovl (
		.clk      (clk),
		.arst_n   (arst_n),
		.box      (box_q),
		.in_valid (rd_vld_q),
		.plat     (rd_plat),
		.res      (hit),
		.busy     (unit_busy)
	);

	// Sequencer: idle, walk the table issuing one read a cycle, drain the
	// overlap pipeline, then hand the result to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_idx_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= (state_q == ST_WALK);
			case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					if (req_fire && is_query) begin
						state_q <= pit_fall ? ST_RESULT : ST_WALK;
					end
				end
				ST_WALK: begin
					if (walk_last) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
				end
				ST_DRAIN: begin
					if (!rd_vld_q && !unit_busy) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Table fill count, lowest bottom and pit margin.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lowest_q <= acpr_pkg::LOWEST_RST;
			margin_q <= acpr_pkg::PIT_MARGIN_RST;
		end else begin
			if (cfg_we) begin
				margin_q <= cfg_wdata;
			end
			if (req_fire && is_load && !table_full) begin
				count_q <= count_q + CW'(1);
				if (new_bottom > lowest_q) begin
					lowest_q <= new_bottom;
				end
			end else if (req_fire && is_clear) begin
				count_q <= '0;
				lowest_q <= acpr_pkg::LOWEST_RST;
			end
		end
	end

	assign mag_ext = $signed({{(ACC_W-acpr_pkg::SIZE_W){1'b0}}, hit.mag});

	// Query capture and accumulation of the per-platform verdicts. Every
	// platform is tested against the box as given, so the order of the sums
	// does not matter, and a zeroed velocity stays zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ground_q <= 1'b0;
			hitd_q <= 1'b0;
			fell_q <= 1'b0;
		end else if (req_fire && is_query) begin
			ground_q <= 1'b0;
			hitd_q <= 1'b0;
			fell_q <= pit_fall;
		end else if (hit.valid && hit.hit && hit.vert && hit.neg) begin
			ground_q <= 1'b1;
			if (hit.deadly) begin
				hitd_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire && is_query) begin
			box_q.left <= req.box_left;
			box_q.top <= req.box_top;
			box_q.right <= new_right;
			box_q.bottom <= new_bottom;
			vx_q <= req.vel_x;
			vy_q <= req.vel_y;
			cx_q <= '0;
			cy_q <= '0;
		end else if (hit.valid && hit.hit) begin
			if (hit.vert) begin
				vy_q <= '0;
				cy_q <= hit.neg ? (cy_q - mag_ext) : (cy_q + mag_ext);
			end else begin
				vx_q <= '0;
				cx_q <= hit.neg ? (cx_q - mag_ext) : (cx_q + mag_ext);
			end
		end
	end

	// Saturate the sums to the coordinate range: in range when every bit
	// above the coordinate's sign bit equals it.
	always_comb begin
		if ((&cx_q[ACC_W-1:CWD-1]) || !(|cx_q[ACC_W-1:CWD-1])) begin
			cx_sat = cx_q[CWD-1:0];
		end else begin
			cx_sat = cx_q[ACC_W-1] ? {1'b1, {(CWD-1){1'b0}}} : {1'b0, {(CWD-1){1'b1}}};
		end
		if ((&cy_q[ACC_W-1:CWD-1]) || !(|cy_q[ACC_W-1:CWD-1])) begin
			cy_sat = cy_q[CWD-1:0];
		end else begin
			cy_sat = cy_q[ACC_W-1] ? {1'b1, {(CWD-1){1'b0}}} : {1'b0, {(CWD-1){1'b1}}};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (state_q == ST_RESULT && rsp_free) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && rsp_free) begin
			rsp_cx_q <= cx_sat;
			rsp_cy_q <= cy_sat;
			rsp_vx_q <= vx_q;
			rsp_vy_q <= vy_q;
			rsp_ground_q <= ground_q;
			rsp_fell_q <= fell_q;
			rsp_hitd_q <= hitd_q;
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.corr_x = rsp_cx_q;
	assign rsp.corr_y = rsp_cy_q;
	assign rsp.new_vel_x = rsp_vx_q;
	assign rsp.new_vel_y = rsp_vy_q;
	assign rsp.on_ground = rsp_ground_q;
	assign rsp.fell_in_pit = rsp_fell_q;
	assign rsp.hit_deadly = rsp_hitd_q;

`ifndef SYNTHESIS
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!rd_vld_q && !unit_busy))
		else $error("overlap pipeline active while idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_PLATFORMS))
		else $error("platform count beyond table depth");

	a_fall_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_vld_q && rsp_fell_q) |->
		(rsp_cx_q == '0 && rsp_cy_q == '0 && !rsp_ground_q && !rsp_hitd_q))
		else $error("pit response carries collision data");

	a_deadly_ground: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_vld_q && rsp_hitd_q) |-> rsp_ground_q)
		else $error("deadly contact without ground contact");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (count_q != '0 && rd_idx_q < count_q))
		else $error("table walk outside the filled entries");
`endif

endmodule

// ===== rtl/core/acpr_plat_ram.sv =====
// Platform table memory: one write port, one registered read port.
// Depends on acpr_pkg for the entry type.
`timescale 1ns / 1ps

module acpr_plat_ram #(
	parameter int DEPTH = acpr_pkg::MAX_PLATFORMS_DEF,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input acpr_pkg::plat_t wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output acpr_pkg::plat_t rdata
);

	acpr_pkg::plat_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/acpr_overlap_unit.sv =====
// Shared three-stage overlap unit: tests one platform per cycle against the box.
// Depends on acpr_pkg for the box, platform and verdict types.
`timescale 1ns / 1ps

module acpr_overlap_unit (
	input logic clk,
	input logic arst_n,
	input acpr_pkg::box_t box,
	input logic in_valid,
	input acpr_pkg::plat_t plat,
	output acpr_pkg::hit_t res,
	output logic busy
);

	localparam int EW = acpr_pkg::EXT_W;
	localparam int OW = EW + 1;

	// Stage 1: platform far edges, near-edge maxima and side flags.
	logic v_s1;
	logic signed [EW-1:0] pr_s1, pb_s1;
	logic signed [acpr_pkg::COORD_W-1:0] lmax_s1, tmax_s1;
	logic ltx_s1, lty_s1, dly_s1;

	// Stage 2: overlap extents.
	logic v_s2;
	logic signed [OW-1:0] ix_s2, iy_s2;
	logic ltx_s2, lty_s2, dly_s2;

	// Stage 3: the verdict.
	logic v_s3;
	logic hit_s3, vert_s3, neg_s3, dly_s3;
	logic [acpr_pkg::SIZE_W-1:0] mag_s3;

	logic signed [EW-1:0] rmin, bmin;
	logic ix_pos, iy_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		pr_s1 <= $signed({plat.left[acpr_pkg::COORD_W-1], plat.left})
			+ $signed({1'b0, {(EW-acpr_pkg::SIZE_W-1){1'b0}}, plat.width});
		pb_s1 <= $signed({plat.top[acpr_pkg::COORD_W-1], plat.top})
			+ $signed({1'b0, {(EW-acpr_pkg::SIZE_W-1){1'b0}}, plat.height});
		ltx_s1 <= box.left < plat.left;
		lty_s1 <= box.top < plat.top;
		lmax_s1 <= (box.left < plat.left) ? plat.left : box.left;
		tmax_s1 <= (box.top < plat.top) ? plat.top : box.top;
		dly_s1 <= plat.deadly;
	end

	assign rmin = (box.right < pr_s1) ? box.right : pr_s1;
	assign bmin = (box.bottom < pb_s1) ? box.bottom : pb_s1;

	always_ff @(posedge clk) begin
		ix_s2 <= $signed({rmin[EW-1], rmin})
			- $signed({{2{lmax_s1[acpr_pkg::COORD_W-1]}}, lmax_s1});
		iy_s2 <= $signed({bmin[EW-1], bmin})
			- $signed({{2{tmax_s1[acpr_pkg::COORD_W-1]}}, tmax_s1});
		ltx_s2 <= ltx_s1;
		lty_s2 <= lty_s1;
		dly_s2 <= dly_s1;
	end

	// A positive overlap never exceeds the narrower box, so it fits the size width.
	assign ix_pos = !ix_s2[OW-1] && (|ix_s2);
	assign iy_pos = !iy_s2[OW-1] && (|iy_s2);

	always_ff @(posedge clk) begin
		hit_s3 <= ix_pos && iy_pos;
		vert_s3 <= ix_s2 > iy_s2;
		neg_s3 <= (ix_s2 > iy_s2) ? lty_s2 : ltx_s2;
		mag_s3 <= (ix_s2 > iy_s2) ? iy_s2[acpr_pkg::SIZE_W-1:0] : ix_s2[acpr_pkg::SIZE_W-1:0];
		dly_s3 <= dly_s2;
	end

	assign res = '{valid: v_s3, hit: hit_s3, vert: vert_s3, neg: neg_s3, deadly: dly_s3,
		mag: mag_s3};

	assign busy = v_s1 || v_s2 || v_s3;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench of the platform collision resolver: directed and random items.
// Depends on acpr_pkg, the acpr_req_if and acpr_rsp_if interfaces and the resolver RTL.
`timescale 1ns / 1ps

module tb;
	import acpr_pkg::*;

	localparam int TABLE_DEPTH = MAX_PLATFORMS_DEF;
	localparam longint S20_LO = -524288;
	localparam longint S20_HI = 524287;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 100;
	localparam int LONG_HOLD = 600;
	localparam int PHASE_ITEMS = 350;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// One request item as it is put on the request channel.
	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic signed [COORD_W-1:0] box_left;
		logic signed [COORD_W-1:0] box_top;
		logic [SIZE_W-1:0] box_width;
		logic [SIZE_W-1:0] box_height;
		logic deadly;
		logic signed [COORD_W-1:0] vel_x;
		logic signed [COORD_W-1:0] vel_y;
	} cmd_item_t;

	// One response item: the resolved motion of the queried box.
	typedef struct {
		logic signed [COORD_W-1:0] corr_x;
		logic signed [COORD_W-1:0] corr_y;
		logic signed [COORD_W-1:0] new_vel_x;
		logic signed [COORD_W-1:0] new_vel_y;
		logic on_ground;
		logic fell_in_pit;
		logic hit_deadly;
	} landing_t;

	// A stimulus row. When fixed_on is set, the typed-in landing is expected
	// instead of the one computed by the predictor.
	typedef struct {
		cmd_item_t item;
		bit fixed_on;
		landing_t fixed;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [MARGIN_W-1:0] cfg_wdata;

	acpr_req_if req();
	acpr_rsp_if rsp();

	aabb_platform_collision_resolver dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Predictor copy of the platform table, the pit floor and the margin.
	longint plat_x[TABLE_DEPTH];
	longint plat_y[TABLE_DEPTH];
	longint plat_w[TABLE_DEPTH];
	longint plat_h[TABLE_DEPTH];
	bit plat_hot[TABLE_DEPTH];
	int plat_n;
	longint floor_y;
	longint margin_m;

	// Landings still owed by the block, oldest first.
	landing_t landing_q[$];
	stim_row_t dir_rows[$];

	int err_count = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_token = 0;

	function automatic logic signed [COORD_W-1:0] sat20(longint v);
		if (v < S20_LO)
			return COORD_W'(S20_LO);
		if (v > S20_HI)
			return COORD_W'(S20_HI);
		return COORD_W'(v);
	endfunction

	// Resolves a query box against every stored platform. Each platform is
	// tested against the box as given, so earlier corrections never move it.
	function automatic landing_t resolve_query(cmd_item_t q);
		longint bl, bt, br, bb, pr, pb, ix, iy, cx, cy;
		landing_t r;
		int i;
		bl = q.box_left;
		bt = q.box_top;
		br = bl + longint'(q.box_width);
		bb = bt + longint'(q.box_height);
		cx = 0;
		cy = 0;
		r.new_vel_x = q.vel_x;
		r.new_vel_y = q.vel_y;
		r.on_ground = 1'b0;
		r.fell_in_pit = 1'b0;
		r.hit_deadly = 1'b0;
		if (plat_n == 0 || bt > floor_y + margin_m) begin
			r.fell_in_pit = 1'b1;
		end else begin
			for (i = 0; i < plat_n; i++) begin
				pr = plat_x[i] + plat_w[i];
				pb = plat_y[i] + plat_h[i];
				ix = (br < pr ? br : pr) - (bl > plat_x[i] ? bl : plat_x[i]);
				iy = (bb < pb ? bb : pb) - (bt > plat_y[i] ? bt : plat_y[i]);
				// Contact needs a strictly positive overlap on both axes.
				if (ix > 0 && iy > 0) begin
					// Wider in x than in y means a hit from above or below;
					// a tie counts as a side hit.
					if (ix > iy) begin
						r.new_vel_y = '0;
						if (bt < plat_y[i]) begin
							cy -= iy;
							r.on_ground = 1'b1;
							if (plat_hot[i])
								r.hit_deadly = 1'b1;
						end else begin
							cy += iy;
						end
					end else begin
						r.new_vel_x = '0;
						if (bl < plat_x[i])
							cx -= ix;
						else
							cx += ix;
					end
				end
			end
		end
		// Sums are kept at full width and clamped once at the end.
		r.corr_x = sat20(cx);
		r.corr_y = sat20(cy);
		return r;
	endfunction

	function automatic stim_row_t rnd_row();
		stim_row_t r;
		r.item.cmd = CMD_W'($urandom_range(3));
		r.item.box_left = COORD_W'($urandom);
		r.item.box_top = COORD_W'($urandom);
		r.item.box_width = SIZE_W'($urandom);
		r.item.box_height = SIZE_W'($urandom);
		r.item.deadly = 1'($urandom_range(1));
		r.item.vel_x = COORD_W'($urandom);
		r.item.vel_y = COORD_W'($urandom);
		r.fixed_on = 1'b0;
		r.fixed = '{default: '0};
		return r;
	endfunction

	task automatic add_row(logic [CMD_W-1:0] c, int l, int t, int w, int h, bit d,
			int vx, int vy, bit fixed_on = 1'b0, int cx = 0, int cy = 0,
			int nvx = 0, int nvy = 0, bit g = 1'b0, bit f = 1'b0, bit hd = 1'b0);
		stim_row_t r;
		r.item.cmd = c;
		r.item.box_left = COORD_W'(l);
		r.item.box_top = COORD_W'(t);
		r.item.box_width = SIZE_W'(w);
		r.item.box_height = SIZE_W'(h);
		r.item.deadly = d;
		r.item.vel_x = COORD_W'(vx);
		r.item.vel_y = COORD_W'(vy);
		r.fixed_on = fixed_on;
		r.fixed.corr_x = COORD_W'(cx);
		r.fixed.corr_y = COORD_W'(cy);
		r.fixed.new_vel_x = COORD_W'(nvx);
		r.fixed.new_vel_y = COORD_W'(nvy);
		r.fixed.on_ground = g;
		r.fixed.fell_in_pit = f;
		r.fixed.hit_deadly = hd;
		dir_rows.insert(dir_rows.size(), r);
	endtask

	// Offers one item after a random idle gap and waits until it is taken.
	// The predictor state moves at the same edge at which the block takes it.
	// The task starts and ends in the time step of a rising edge, so the
	// valid of back-to-back items is assigned only once per step.
	task automatic drive_item(stim_row_t r);
		int gap;
		gap = 0;
		while (int'($urandom_range(99)) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= r.item.cmd;
		req.box_left <= r.item.box_left;
		req.box_top <= r.item.box_top;
		req.box_width <= r.item.box_width;
		req.box_height <= r.item.box_height;
		req.deadly <= r.item.deadly;
		req.vel_x <= r.item.vel_x;
		req.vel_y <= r.item.vel_y;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		case (r.item.cmd)
			CMD_LOAD: begin
				// A load into a full table is dropped and leaves the floor alone.
				if (plat_n < TABLE_DEPTH) begin
					plat_x[plat_n] = r.item.box_left;
					plat_y[plat_n] = r.item.box_top;
					plat_w[plat_n] = longint'(r.item.box_width);
					plat_h[plat_n] = longint'(r.item.box_height);
					plat_hot[plat_n] = r.item.deadly;
					if (plat_y[plat_n] + plat_h[plat_n] > floor_y)
						floor_y = plat_y[plat_n] + plat_h[plat_n];
					plat_n++;
				end
			end
			CMD_CLEAR: begin
				plat_n = 0;
				floor_y = LOWEST_RST;
			end
			CMD_QUERY: begin
				landing_q.insert(landing_q.size(),
					r.fixed_on ? r.fixed : resolve_query(r.item));
			end
			default: begin
			end
		endcase
		if (r.item.cmd != CMD_UNUSED)
			items_sent++;
	endtask

	// Withdraws the request, waits until every owed landing has come back,
	// then lets the block finish any load or clear that was still in flight.
	task automatic settle();
		req.valid <= 1'b0;
		while (landing_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_margin(logic [MARGIN_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		margin_m = longint'(v);
	endtask

	// A scene is the well-formed sequence that reaches deep into the block:
	// clear the table, load a cluster of platforms, then throw boxes at them.
	// Now and then the table is overfilled, and some queries probe the pit
	// floor right at its boundary.
	task automatic run_scene();
		stim_row_t r;
		int n_plat, n_q, i, j, ox, oy, bw, bh;
		longint pit_y;
		ox = int'($urandom_range(800000)) - 400000;
		oy = int'($urandom_range(800000)) - 400000;
		r = rnd_row();
		r.item.cmd = CMD_CLEAR;
		drive_item(r);
		if (int'($urandom_range(99)) < 4)
			n_plat = int'($urandom_range(70, 60));
		else
			n_plat = int'($urandom_range(8, 1));
		for (i = 0; i < n_plat; i++) begin
			r = rnd_row();
			r.item.cmd = CMD_LOAD;
			r.item.box_left = COORD_W'(ox + int'($urandom_range(3000)) - 1500);
			r.item.box_top = COORD_W'(oy + int'($urandom_range(3000)) - 1500);
			// Mostly modest platforms so that boxes meet several at once.
			if ($urandom_range(9) != 0) begin
				r.item.box_width = SIZE_W'($urandom_range(800, 1));
				r.item.box_height = SIZE_W'($urandom_range(800, 1));
			end
			drive_item(r);
		end
		n_q = int'($urandom_range(8, 2));
		for (i = 0; i < n_q; i++) begin
			r = rnd_row();
			r.item.cmd = CMD_QUERY;
			j = int'($urandom_range(plat_n - 1));
			bw = ($urandom_range(15) == 0) ? int'($urandom_range(65535))
				: int'($urandom_range(800));
			bh = ($urandom_range(15) == 0) ? int'($urandom_range(65535))
				: int'($urandom_range(800));
			r.item.box_width = SIZE_W'(bw);
			r.item.box_height = SIZE_W'(bh);
			// Place the box anywhere from just left of the platform to just
			// right of it, edge contact included.
			r.item.box_left = sat20(plat_x[j] - bw
				+ longint'($urandom_range(int'(plat_w[j]) + bw)));
			r.item.box_top = sat20(plat_y[j] - bh
				+ longint'($urandom_range(int'(plat_h[j]) + bh)));
			if ($urandom_range(7) == 0) begin
				pit_y = floor_y + margin_m + longint'($urandom_range(2)) - 1;
				r.item.box_top = sat20(pit_y);
			end
			drive_item(r);
		end
	endtask

	// Random part of one phase: mostly scenes, the rest unshaped items of any
	// command, which also yields stray clears and queries on empty tables.
	task automatic run_random(int n);
		int target;
		target = items_sent + n;
		while (items_sent < target) begin
			if ($urandom_range(99) < 75)
				run_scene();
			else
				drive_item(rnd_row());
		end
	endtask

	task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	// Response monitor: every item taken from the block is compared with the
	// oldest owed landing.
	always @(posedge clk) begin
		landing_t want;
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (landing_q.size() == 0) begin
				$error("response item with no query waiting");
				err_count++;
			end else begin
				want = landing_q.pop_front();
				check_field("corr_x", want.corr_x, rsp.corr_x);
				check_field("corr_y", want.corr_y, rsp.corr_y);
				check_field("new_vel_x", want.new_vel_x, rsp.new_vel_x);
				check_field("new_vel_y", want.new_vel_y, rsp.new_vel_y);
				check_field("on_ground", want.on_ground, rsp.on_ground);
				check_field("fell_in_pit", want.fell_in_pit, rsp.fell_in_pit);
				check_field("hit_deadly", want.hit_deadly, rsp.hit_deadly);
			end
		end
	end

	// Response ready. A new hold token starts a long hold-off counted here,
	// during which the sender keeps offering and the block backs up.
	initial begin
		int hold_seen, hold_left;
		hold_seen = 0;
		hold_left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= (int'($urandom_range(99)) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("aabb_platform_collision_resolver test failed");
			$finish;
		end
	end

	initial begin
		int k;
		logic [MARGIN_W-1:0] margins[5];
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.cmd <= CMD_LOAD;
		req.box_left <= '0;
		req.box_top <= '0;
		req.box_width <= '0;
		req.box_height <= '0;
		req.deadly <= 1'b0;
		req.vel_x <= '0;
		req.vel_y <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		plat_n = 0;
		floor_y = LOWEST_RST;
		margin_m = longint'(PIT_MARGIN_RST);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run with the margin as it comes out of reset.
		// An empty table always falls; the unused command gives nothing.
		add_row(CMD_QUERY, 100, 200, 16, 16, 0, 50, -70, 1, 0, 0, 50, -70, 0, 1, 0);
		add_row(CMD_UNUSED, 0, 0, 16, 16, 1, 1, 1);
		// A platform of zero size at the coordinate extremes touches nothing,
		// and extreme velocities pass through untouched.
		add_row(CMD_LOAD, -524288, 524287, 0, 0, 1, 0, 0);
		add_row(CMD_QUERY, -524288, -524288, 65535, 65535, 1, 524287, -524288,
			1, 0, 0, 524287, -524288, 0, 0, 0);
		add_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		add_row(CMD_QUERY, 0, 0, 16, 16, 0, -1, 1, 1, 0, 0, -1, 1, 0, 1, 0);
		// Nine stacked maximal platforms drive every correction sum out of
		// range in each of the four push directions.
		for (k = 0; k < 9; k++)
			add_row(CMD_LOAD, 0, 0, 65535, 65535, 1'(k % 2), 0, 0);
		add_row(CMD_QUERY, 0, -1, 65535, 65535, 0, 123, 456,
			1, 0, -524288, 123, 0, 1, 0, 1);
		add_row(CMD_QUERY, 0, 1, 65535, 65535, 0, 123, 456,
			1, 0, 524287, 123, 0, 0, 0, 0);
		add_row(CMD_QUERY, -1, 0, 65535, 65535, 0, 123, 456,
			1, -524288, 0, 0, 456, 0, 0, 0);
		add_row(CMD_QUERY, 1, 0, 65535, 65535, 0, 123, 456,
			1, 524287, 0, 0, 456, 0, 0, 0);
		// Equal overlap on both axes, edge contact on either side, and a
		// partial overlap are left to the predictor.
		add_row(CMD_QUERY, 1, 1, 65535, 65535, 0, 7, 8);
		add_row(CMD_QUERY, 65535, 0, 16, 16, 0, 5, 5);
		add_row(CMD_QUERY, -16, 100, 16, 16, 0, 5, 5);
		add_row(CMD_QUERY, 100, -10, 32, 32, 0, 9, 9);
		// The pit floor is 65535 + 3200: the box right on it stays, one
		// step further falls.
		add_row(CMD_QUERY, 0, 68735, 16, 16, 0, 3, 4, 1, 0, 0, 3, 4, 0, 0, 0);
		add_row(CMD_QUERY, 0, 68736, 16, 16, 0, 3, 4, 1, 0, 0, 3, 4, 0, 1, 0);
		foreach (dir_rows[i])
			drive_item(dir_rows[i]);

		// Random phases, each with its own margin and a chosen idling pattern. The
		// last phase opens with the long receiver hold-off.
		margins[0] = '0;
		margins[1] = '1;
		margins[2] = PIT_MARGIN_RST;
		margins[3] = MARGIN_W'($urandom);
		margins[4] = MARGIN_W'($urandom_range(8000));
		for (k = 0; k < 5; k++) begin
			write_margin(margins[k]);
			case (k)
				1: begin
					send_idle_pct = 54;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 54;
				end
				3: begin
					send_idle_pct = 20;
					recv_stall_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			if (k == 4)
				hold_token <= hold_token + 1;
			run_random(PHASE_ITEMS);
		end

		settle();
		if (err_count == 0)
			$display("aabb_platform_collision_resolver test passed");
		else
			$display("aabb_platform_collision_resolver test failed");
		$finish;
	end

endmodule
